[sv/tsi_pkg.sv]
// ----------------------------------------------------------------------------
// tsi_pkg
// Shared types, codes and table helpers of the turtle symbol interpreter.
// ----------------------------------------------------------------------------
package tsi_pkg;

    localparam int STACK_DEPTH_DEF  = 64;
    localparam int SINE_ENTRIES_DEF = 1024;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam int CQ_AW    = 2;
    localparam int CQ_DEPTH = 1 << CQ_AW;
    localparam int RQ_AW    = 2;
    localparam int RQ_DEPTH = 1 << RQ_AW;

    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_STEP  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_ANGLE = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_LENGTH = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X    = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y    = 8'd4;

    localparam logic [15:0] ANGLE_STEP_RST  = 16'd10923;
    localparam logic [15:0] START_ANGLE_RST = 16'd0;
    localparam logic [15:0] STEP_LENGTH_RST = 16'd2560;
    localparam logic [23:0] ORIGIN_RST      = 24'd0;

    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_MINUS = 8'h2D;
    localparam logic [7:0] SYM_DRAW  = 8'h46;
    localparam logic [7:0] SYM_MOVE  = 8'h62;
    localparam logic [7:0] SYM_PUSH  = 8'h5B;
    localparam logic [7:0] SYM_POP   = 8'h5D;

    localparam logic [1:0] ST_SEGMENT   = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PLUS,
        OP_MINUS,
        OP_DRAW,
        OP_MOVE,
        OP_PUSH,
        OP_POP
    } op_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       word_start;
    } sym_item_t;

    typedef struct packed {
        logic signed [23:0] seg_x_start;
        logic signed [23:0] seg_y_start;
        logic signed [23:0] seg_x_end;
        logic signed [23:0] seg_y_end;
        logic        [1:0]  status;
    } seg_item_t;

    typedef struct packed {
        op_t  op;
        logic word_start;
    } cmd_t;

    typedef struct packed {
        logic        [15:0] angle_step;
        logic        [15:0] start_angle;
        logic        [15:0] step_length;
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
    } cfg_t;

    function automatic logic [63:0] sq_step(logic [63:0] term, logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        return (t * x) >> 30;
    endfunction

    function automatic logic [15:0] quarter_sine(logic [63:0] f);
        logic        [63:0] x;
        logic        [63:0] term;
        logic signed [63:0] sum;
        logic        [63:0] r;
        x    = (f * HALF_PI_Q30) >> 30;
        term = x;
        sum  = $signed(x);
        term = sq_step(term, x) / 64'd6;
        sum  = sum - $signed(term);
        term = sq_step(term, x) / 64'd20;
        sum  = sum + $signed(term);
        term = sq_step(term, x) / 64'd42;
        sum  = sum - $signed(term);
        term = sq_step(term, x) / 64'd72;
        sum  = sum + $signed(term);
        term = sq_step(term, x) / 64'd110;
        sum  = sum - $signed(term);
        term = sq_step(term, x) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        r = ($unsigned(sum) + 64'd16384) >> 15;
        if (r > 64'd32767)
        begin
            r = 64'd32767;
        end
        return r[15:0];
    endfunction

endpackage

[sv/tsi_front.sv]
// ----------------------------------------------------------------------------
// tsi_front
// Symbol intake: decodes each symbol into a command and queues it for the
// execution side. Symbols with no effect are dropped here unless they start a word.
// ----------------------------------------------------------------------------
module tsi_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  tsi_pkg::sym_item_t item,
    output logic               cmd_valid,
    output tsi_pkg::cmd_t      cmd,
    input  logic               cmd_take
);
    import tsi_pkg::*;

    op_t              op;
    logic             keep;
    logic             wr;
    logic             rd;
    cmd_t             q_reg [CQ_DEPTH];
    logic [CQ_AW-1:0] wr_ptr_reg;
    logic [CQ_AW-1:0] rd_ptr_reg;
    logic [CQ_AW:0]   count_reg;
    logic [CQ_AW:0]   count_next;

    always_comb
    begin
        unique case (item.symbol)
            SYM_PLUS:  op = OP_PLUS;
            SYM_MINUS: op = OP_MINUS;
            SYM_DRAW:  op = OP_DRAW;
            SYM_MOVE:  op = OP_MOVE;
            SYM_PUSH:  op = OP_PUSH;
            SYM_POP:   op = OP_POP;
            default:   op = OP_NONE;
        endcase
    end

    assign full      = (count_reg == (CQ_AW+1)'(CQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign keep      = (op != OP_NONE) || item.word_start;
    assign wr        = push && !full && keep;
    assign rd        = cmd_take && cmd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + (CQ_AW+1)'(1);
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - (CQ_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + CQ_AW'(1);
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + CQ_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wr_ptr_reg] <= '{op: op, word_start: item.word_start};
        end
    end

endmodule

[sv/tsi_sine_rom.sv]
// ----------------------------------------------------------------------------
// tsi_sine_rom
// Full-turn sine table in Q1.15 with two registered read ports.
// ----------------------------------------------------------------------------
module tsi_sine_rom
#(
    parameter int SINE_ENTRIES = tsi_pkg::SINE_ENTRIES_DEF
)
(
    input  logic                            clk,
    input  logic                            en,
    input  logic [$clog2(SINE_ENTRIES)-1:0] sin_addr,
    input  logic [$clog2(SINE_ENTRIES)-1:0] cos_addr,
    output logic signed [15:0]              sin_reg,
    output logic signed [15:0]              cos_reg
);
    import tsi_pkg::*;

    function automatic logic [SINE_ENTRIES*16-1:0] build_rom();
        logic [SINE_ENTRIES*16-1:0] rom;
        logic [63:0]                a4;
        logic [63:0]                quad;
        logic [63:0]                rem;
        logic [63:0]                f;
        logic [15:0]                s;
        rom = '0;
        for (int k = 0; k < SINE_ENTRIES; k++)
        begin
            a4   = 64'(4 * k);
            quad = a4 / SINE_ENTRIES;
            rem  = a4 % SINE_ENTRIES;
            if (quad[0])
            begin
                f = ((64'(SINE_ENTRIES) - rem) << 30) / SINE_ENTRIES;
            end
            else
            begin
                f = (rem << 30) / SINE_ENTRIES;
            end
            s = quarter_sine(f);
            rom[k*16 +: 16] = quad[1] ? (16'd0 - s) : s;
        end
        return rom;
    endfunction

    localparam logic [SINE_ENTRIES*16-1:0] SINE_ROM = build_rom();

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= $signed(SINE_ROM[{sin_addr, 4'b0000} +: 16]);
            cos_reg <= $signed(SINE_ROM[{cos_addr, 4'b0000} +: 16]);
        end
    end

endmodule

[sv/tsi_back.sv]
// ----------------------------------------------------------------------------
// tsi_back
// Turtle execution: heading and stack at issue, table read, step multiply,
// then position update and segment output.
// ----------------------------------------------------------------------------
module tsi_back
#(
    parameter int STACK_DEPTH  = tsi_pkg::STACK_DEPTH_DEF,
    parameter int SINE_ENTRIES = tsi_pkg::SINE_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tsi_pkg::cfg_t      cfg,
    input  logic               cmd_valid,
    input  tsi_pkg::cmd_t      cmd,
    output logic               cmd_take,
    input  logic               res_full,
    output logic               res_wr,
    output tsi_pkg::seg_item_t res_data
);
    import tsi_pkg::*;

    localparam int IDX_W  = $clog2(SINE_ENTRIES);
    localparam int PROD_W = 16 + IDX_W;
    localparam int SA_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);

    typedef struct packed {
        logic        [15:0] hd;
        logic signed [23:0] x;
        logic signed [23:0] y;
    } stack_entry_t;

    logic               adv;
    logic               drained;
    logic               issue;
    logic [15:0]        hd_cur;
    logic [LVL_W-1:0]   lvl_cur;
    logic [LVL_W-1:0]   pop_lvl;
    logic               push_ok;
    logic               pop_ok;
    logic               stack_err;
    logic               to_e1;
    logic [15:0]        heading_next;
    logic [LVL_W-1:0]   level_next;
    logic [15:0]        cos_hd;
    logic [PROD_W-1:0]  sin_prod;
    logic [PROD_W-1:0]  cos_prod;
    logic signed [23:0] push_x;
    logic signed [23:0] push_y;

    logic [15:0]        heading_reg;
    logic [LVL_W-1:0]   level_reg;
    logic signed [23:0] pos_x_reg;
    logic signed [23:0] pos_y_reg;
    logic               pop_busy_reg;

    stack_entry_t       stack_mem [STACK_DEPTH];
    stack_entry_t       pop_data_reg;

    logic signed [15:0] sin_reg;
    logic signed [15:0] cos_reg;

    logic               e1_v_reg;
    op_t                e1_op_reg;
    logic               e1_ws_reg;
    logic               e1_err_reg;
    logic [1:0]         e1_status_reg;
    logic [14:0]        mag_x;
    logic [14:0]        mag_y;

    logic               e2_v_reg;
    op_t                e2_op_reg;
    logic               e2_ws_reg;
    logic               e2_err_reg;
    logic [1:0]         e2_status_reg;
    logic [30:0]        e2_prod_x_reg;
    logic [30:0]        e2_prod_y_reg;
    logic               e2_neg_x_reg;
    logic               e2_neg_y_reg;

    logic               e2_draw;
    logic               e2_moves;
    logic [31:0]        sum_x;
    logic [31:0]        sum_y;
    logic [23:0]        dx;
    logic [23:0]        dy;
    logic signed [23:0] base_x;
    logic signed [23:0] base_y;
    logic signed [23:0] end_x;
    logic signed [23:0] end_y;

    // issue stage
    assign adv       = !res_full;
    assign drained   = !e1_v_reg && !e2_v_reg;
    assign hd_cur    = cmd.word_start ? cfg.start_angle : heading_reg;
    assign lvl_cur   = cmd.word_start ? '0 : level_reg;
    assign pop_lvl   = lvl_cur - LVL_W'(1);
    assign push_ok   = (cmd.op == OP_PUSH) && (lvl_cur < LVL_W'(STACK_DEPTH));
    assign pop_ok    = (cmd.op == OP_POP) && (lvl_cur != '0);
    assign stack_err = ((cmd.op == OP_PUSH) || (cmd.op == OP_POP)) && !push_ok && !pop_ok;
    assign issue     = adv && cmd_valid && !pop_busy_reg && (!(push_ok || pop_ok) || drained);
    assign cmd_take  = issue;
    assign to_e1     = (cmd.op == OP_DRAW) || (cmd.op == OP_MOVE) || stack_err
                       || cmd.word_start;
    assign push_x    = cmd.word_start ? cfg.origin_x : pos_x_reg;
    assign push_y    = cmd.word_start ? cfg.origin_y : pos_y_reg;

    assign cos_hd   = hd_cur + QUARTER_TURN;
    assign sin_prod = PROD_W'(hd_cur) * PROD_W'(SINE_ENTRIES);
    assign cos_prod = PROD_W'(cos_hd) * PROD_W'(SINE_ENTRIES);

    always_comb
    begin
        unique case (cmd.op)
            OP_PLUS:  heading_next = hd_cur + cfg.angle_step;
            OP_MINUS: heading_next = hd_cur - cfg.angle_step;
            default:  heading_next = hd_cur;
        endcase
        level_next = lvl_cur;
        if (push_ok)
        begin
            level_next = lvl_cur + LVL_W'(1);
        end
        else if (pop_ok)
        begin
            level_next = pop_lvl;
        end
    end

    tsi_sine_rom #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_sine_rom (
        .clk      (clk),
        .en       (issue),
        .sin_addr (sin_prod[PROD_W-1:16]),
        .cos_addr (cos_prod[PROD_W-1:16]),
        .sin_reg  (sin_reg),
        .cos_reg  (cos_reg)
    );

    always_ff @(posedge clk)
    begin
        if (issue && push_ok)
        begin
            stack_mem[lvl_cur[SA_W-1:0]] <= '{hd: hd_cur, x: push_x, y: push_y};
        end
        if (issue && pop_ok)
        begin
            pop_data_reg <= stack_mem[pop_lvl[SA_W-1:0]];
        end
    end

    // multiply stage
    assign mag_x = cos_reg[15] ? 15'(16'sd0 - cos_reg) : cos_reg[14:0];
    assign mag_y = sin_reg[15] ? 15'(16'sd0 - sin_reg) : sin_reg[14:0];

    // position stage
    assign e2_draw  = (e2_op_reg == OP_DRAW);
    assign e2_moves = e2_draw || (e2_op_reg == OP_MOVE);
    assign sum_x    = 32'(e2_prod_x_reg) + 32'd16384;
    assign sum_y    = 32'(e2_prod_y_reg) + 32'd16384;
    assign dx       = e2_neg_x_reg ? (24'd0 - 24'(sum_x[31:15])) : 24'(sum_x[31:15]);
    assign dy       = e2_neg_y_reg ? (24'd0 - 24'(sum_y[31:15])) : 24'(sum_y[31:15]);
    assign base_x   = e2_ws_reg ? cfg.origin_x : pos_x_reg;
    assign base_y   = e2_ws_reg ? cfg.origin_y : pos_y_reg;
    assign end_x    = base_x + $signed(dx);
    assign end_y    = base_y + $signed(dy);

    assign res_wr = adv && e2_v_reg && (e2_draw || e2_err_reg);

    always_comb
    begin
        res_data = '0;
        if (e2_err_reg)
        begin
            res_data.status = e2_status_reg;
        end
        else
        begin
            res_data.seg_x_start = base_x;
            res_data.seg_y_start = base_y;
            res_data.seg_x_end   = end_x;
            res_data.seg_y_end   = end_y;
            res_data.status      = ST_SEGMENT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg  <= START_ANGLE_RST;
            level_reg    <= '0;
            pos_x_reg    <= ORIGIN_RST;
            pos_y_reg    <= ORIGIN_RST;
            pop_busy_reg <= 1'b0;
            e1_v_reg     <= 1'b0;
            e2_v_reg     <= 1'b0;
        end
        else if (adv)
        begin
            e1_v_reg <= issue && to_e1;
            e2_v_reg <= e1_v_reg;
            if (pop_busy_reg)
            begin
                heading_reg  <= pop_data_reg.hd;
                pos_x_reg    <= pop_data_reg.x;
                pos_y_reg    <= pop_data_reg.y;
                pop_busy_reg <= 1'b0;
            end
            else if (issue)
            begin
                heading_reg  <= heading_next;
                level_reg    <= level_next;
                pop_busy_reg <= pop_ok;
                if (push_ok)
                begin
                    pos_x_reg <= push_x;
                    pos_y_reg <= push_y;
                end
            end
            if (e2_v_reg && !pop_busy_reg)
            begin
                if (e2_moves)
                begin
                    pos_x_reg <= end_x;
                    pos_y_reg <= end_y;
                end
                else
                begin
                    pos_x_reg <= base_x;
                    pos_y_reg <= base_y;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_op_reg     <= cmd.op;
            e1_ws_reg     <= cmd.word_start;
            e1_err_reg    <= stack_err;
            e1_status_reg <= (cmd.op == OP_PUSH) ? ST_OVERFLOW : ST_UNDERFLOW;
            e2_op_reg     <= e1_op_reg;
            e2_ws_reg     <= e1_ws_reg;
            e2_err_reg    <= e1_err_reg;
            e2_status_reg <= e1_status_reg;
            e2_prod_x_reg <= 31'(mag_x) * 31'(cfg.step_length);
            e2_prod_y_reg <= 31'(mag_y) * 31'(cfg.step_length);
            e2_neg_x_reg  <= cos_reg[15];
            e2_neg_y_reg  <= sin_reg[15];
        end
    end

endmodule

[sv/tsi_result_queue.sv]
// ----------------------------------------------------------------------------
// tsi_result_queue
// Short queue of finished segment and error results toward the consumer.
// ----------------------------------------------------------------------------
module tsi_result_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  tsi_pkg::seg_item_t wr_data,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output tsi_pkg::seg_item_t rd_data
);
    import tsi_pkg::*;

    seg_item_t        q_reg [RQ_DEPTH];
    logic [RQ_AW-1:0] wr_ptr_reg;
    logic [RQ_AW-1:0] rd_ptr_reg;
    logic [RQ_AW:0]   count_reg;
    logic [RQ_AW:0]   count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == (RQ_AW+1)'(RQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = q_reg[rd_ptr_reg];
    assign do_wr   = wr && !full;
    assign do_rd   = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (RQ_AW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (RQ_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + RQ_AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + RQ_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[sv/turtle_symbol_interpreter.sv]
// ----------------------------------------------------------------------------
// turtle_symbol_interpreter
// L-system turtle: turns, moves and bracket stack, one symbol per transaction.
//
//   Channel   Handshake              Payload
//   symbols   push / full            item   (symbol, word_start)
//   results   empty / pop            result (segment ends, status)
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Turns, moves and ignored symbols issue back to back without waiting for
// earlier moves; ignored symbols without word_start are dropped on entry.
// A segment passes the table read and multiply registers to the result queue.
// '[' and ']' that act on the stack wait for the move pipeline to empty;
// ']' also waits for the stack memory read before the next symbol issues.
// Reset clears control state only; the stack memory needs no clearing.
// A full result queue holds the execution side; full rises as the
// four-entry command queue fills.
// ----------------------------------------------------------------------------
module turtle_symbol_interpreter
#(
    parameter int STACK_DEPTH  = tsi_pkg::STACK_DEPTH_DEF,
    parameter int SINE_ENTRIES = tsi_pkg::SINE_ENTRIES_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  tsi_pkg::sym_item_t                 item,
    output logic                               empty,
    input  logic                               pop,
    output tsi_pkg::seg_item_t                 result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tsi_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tsi_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tsi_pkg::*;

    cfg_t      cfg_reg;
    logic      cmd_valid;
    cmd_t      cmd;
    logic      cmd_take;
    logic      res_full;
    logic      res_wr;
    seg_item_t res_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_step  <= ANGLE_STEP_RST;
            cfg_reg.start_angle <= START_ANGLE_RST;
            cfg_reg.step_length <= STEP_LENGTH_RST;
            cfg_reg.origin_x    <= ORIGIN_RST;
            cfg_reg.origin_y    <= ORIGIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ANGLE_STEP:  cfg_reg.angle_step  <= cfg_data[15:0];
                REG_START_ANGLE: cfg_reg.start_angle <= cfg_data[15:0];
                REG_STEP_LENGTH: cfg_reg.step_length <= cfg_data[15:0];
                REG_ORIGIN_X:    cfg_reg.origin_x    <= $signed(cfg_data[23:0]);
                REG_ORIGIN_Y:    cfg_reg.origin_y    <= $signed(cfg_data[23:0]);
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    tsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    tsi_back #(
        .STACK_DEPTH  (STACK_DEPTH),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_full  (res_full),
        .res_wr    (res_wr),
        .res_data  (res_data)
    );

    tsi_result_queue u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_wr),
        .wr_data (res_data),
        .full    (res_full),
        .empty   (empty),
        .pop     (pop),
        .rd_data (result)
    );

endmodule

[sv/tsi_checker.sv]
// ----------------------------------------------------------------------------
// tsi_checker
// Port-level checks of the turtle symbol interpreter, bound to the top level.
// ----------------------------------------------------------------------------
module tsi_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               full,
    input  logic                               empty,
    input  logic                               pop,
    input  tsi_pkg::seg_item_t                 result
);
    import tsi_pkg::*;

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> empty && !full)
        else $error("queues not idle during reset");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.status != ST_SEGMENT
        |-> (result.status == ST_OVERFLOW || result.status == ST_UNDERFLOW)
            && result.seg_x_start == '0 && result.seg_y_start == '0
            && result.seg_x_end == '0 && result.seg_y_end == '0)
        else $error("malformed error result");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed or vanished");

endmodule

bind turtle_symbol_interpreter tsi_checker u_checker (.*);
